FILE: sv/box_blur_3x3_rgb_assert.svh
// Assertion macros for the box blur RTL; only bb3_front uses them.
// Needs nothing else; a synthesis build defines SYNTH to drop the checks.
`ifndef BOX_BLUR_3X3_RGB_ASSERT_SVH
`define BOX_BLUR_3X3_RGB_ASSERT_SVH

`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define BB3_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// An expression that must never be true outside reset.
`define BB3_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define BB3_ASSERT(lbl, clk, rstn, prop, msg)
`define BB3_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

FILE: sv/bb3_pkg.sv
// Shared types, constants and helper functions of the box blur block.
// Used by every RTL file of the block; depends on nothing.
package bb3_pkg;

	// Frame size limits and register defaults.
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int DIM_W      = 12;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int PEND_W     = $clog2(MAX_WIDTH + 2);

	typedef logic [DIM_W-1:0]  dim_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [PEND_W-1:0] pend_t;

	localparam dim_t WIDTH_MIN    = dim_t'(3);
	localparam dim_t WIDTH_MAX    = dim_t'(MAX_WIDTH);
	localparam dim_t HEIGHT_MIN   = dim_t'(2);
	localparam dim_t HEIGHT_MAX   = dim_t'(MAX_HEIGHT);
	localparam dim_t WIDTH_RESET  = dim_t'(640);
	localparam dim_t HEIGHT_RESET = dim_t'(480);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 4;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_IDX_WIDTH  = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_IDX_HEIGHT = cfg_idx_t'(1);

	// Item opcodes.
	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	// A pixel: one byte per channel, blue in the lowest lane.
	localparam int NCH    = 3;
	localparam int CH_W   = 8;
	localparam int CH_BLUE  = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_RED   = 2;
	typedef logic [NCH-1:0][CH_W-1:0] pix_t;

	// Arithmetic widths: row sum of three bytes, window sum of nine.
	localparam int RSUM_W = CH_W + 2;
	localparam int SUM_W  = CH_W + 4;
	typedef logic [RSUM_W-1:0] rsum_t;
	typedef logic [SUM_W-1:0]  sum_t;

	// Divide by nine as multiply by ceil(2^16 / 9) and shift; exact for sums below 2^12.
	localparam int DIV9_SHIFT = 16;
	localparam int DIV9_MUL_W = 13;
	localparam int MUL_W      = SUM_W + DIV9_MUL_W;
	localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = DIV9_MUL_W'((65536 + 8) / 9);
	typedef logic [MUL_W-1:0] prod_t;

	// Queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	typedef logic [QPTR_W-1:0] qptr_t;
	typedef logic [QCNT_W-1:0] qcnt_t;

	// One queued item for the back end.
	typedef struct packed {
		logic is_pixel;   // pixel item: updates the line buffers and window
		logic emit;       // item produces an output pixel
		logic blur;       // output pixel is the window mean
		logic frame_end;  // output pixel is the last of its frame
		logic use_mem;    // drained pixel comes from the newer line buffer
		col_t addr;       // line buffer address
		pix_t pix;        // incoming pixel
	} q_entry_t;

	// Clamp a register value into its legal range.
	function automatic dim_t clamp_dim(input dim_t v, input dim_t lo, input dim_t hi);
		dim_t r;
		r = v;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

FILE: sv/bb3_queue.sv
// Short item queue that decouples the front end from the back end.
// Depends on bb3_pkg for the entry type and depth.
module bb3_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bb3_pkg::q_entry_t push_data,
	input  logic              pop,
	output bb3_pkg::q_entry_t data,
	output logic              empty,
	output logic              full
);

	bb3_pkg::q_entry_t store_q [bb3_pkg::QDEPTH];
	bb3_pkg::qptr_t    wr_ptr_q;
	bb3_pkg::qptr_t    rd_ptr_q;
	bb3_pkg::qcnt_t    count_q;
	bb3_pkg::qptr_t    wr_ptr_nxt;
	bb3_pkg::qptr_t    rd_ptr_nxt;

	// Pointer wrap.
	always_comb begin
		wr_ptr_nxt = (wr_ptr_q == bb3_pkg::qptr_t'(bb3_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
		rd_ptr_nxt = (rd_ptr_q == bb3_pkg::qptr_t'(bb3_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_nxt;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_nxt;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	assign data  = store_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == bb3_pkg::qcnt_t'(bb3_pkg::QDEPTH));

endmodule

FILE: sv/bb3_front.sv
// Front end: configuration registers, frame position and pending count.
// Classifies each item and queues the ones the back end must see. Uses bb3_pkg.
`include "box_blur_3x3_rgb_assert.svh"

module bb3_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  bb3_pkg::cfg_idx_t cfg_index,
	input  bb3_pkg::dim_t     cfg_data,
	input  logic              item_valid,
	input  logic              opcode,
	input  bb3_pkg::pix_t     pix,
	input  logic              q_full,
	output logic              push,
	output bb3_pkg::q_entry_t push_data
);

	bb3_pkg::dim_t  w_q;
	bb3_pkg::dim_t  h_q;
	bb3_pkg::col_t  col_q;
	bb3_pkg::row_t  row_q;
	bb3_pkg::pend_t pend_q;
	bb3_pkg::col_t  ocol_q;
	bb3_pkg::row_t  orow_q;

	logic           acc;
	logic           is_pix;
	logic           px_emit;
	logic           dr_emit;
	logic           out_adv;
	logic           cfg_we;
	logic           cfg_hit;
	logic           blur;
	logic           frame_end;
	logic           use_mem;
	bb3_pkg::col_t  col_nxt;
	bb3_pkg::row_t  row_nxt;
	bb3_pkg::col_t  ocol_nxt;
	bb3_pkg::row_t  orow_nxt;
	bb3_pkg::pend_t pend_nxt;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Only the listed registers take effect.
	always_comb begin
		unique case (cfg_index)
			bb3_pkg::CFG_IDX_WIDTH:  cfg_hit = 1'b1;
			bb3_pkg::CFG_IDX_HEIGHT: cfg_hit = 1'b1;
			default:                 cfg_hit = 1'b0;
		endcase
	end

	// Item classification.
	always_comb begin
		acc     = item_valid && !q_full;
		is_pix  = (bb3_pkg::op_t'(opcode) == bb3_pkg::OP_PIXEL);
		px_emit = (pend_q >= bb3_pkg::pend_t'(w_q) + bb3_pkg::pend_t'(1));
		dr_emit = (col_q == '0) && (row_q == '0) && (pend_q != '0);
		out_adv = is_pix ? px_emit : dr_emit;
	end

	// Next input position: column wraps at width, row wraps at height.
	always_comb begin
		col_nxt = col_q + 1'b1;
		row_nxt = row_q;
		if (bb3_pkg::dim_t'(col_q) == w_q - 1'b1) begin
			col_nxt = '0;
			row_nxt = (bb3_pkg::dim_t'(row_q) == h_q - 1'b1) ? '0 : row_q + 1'b1;
		end
	end

	// Next output position, and what the output pixel there needs.
	always_comb begin
		ocol_nxt = ocol_q + 1'b1;
		orow_nxt = orow_q;
		if (bb3_pkg::dim_t'(ocol_q) == w_q - 1'b1) begin
			ocol_nxt = '0;
			orow_nxt = (bb3_pkg::dim_t'(orow_q) == h_q - 1'b1) ? '0 : orow_q + 1'b1;
		end
		blur = (orow_q != '0) && (bb3_pkg::dim_t'(orow_q) + 2'd2 <= (h_q >> 1))
			&& (ocol_q != '0) && (bb3_pkg::dim_t'(ocol_q) + 2'd2 <= w_q);
		frame_end = (bb3_pkg::dim_t'(orow_q) == h_q - 1'b1)
			&& (bb3_pkg::dim_t'(ocol_q) == w_q - 1'b1);
		use_mem = (bb3_pkg::dim_t'(orow_q) == h_q - 1'b1);
	end

	// Pending count: a pixel adds one unless it pushes one out; a drain removes one.
	always_comb begin
		pend_nxt = pend_q;
		if (is_pix) begin
			if (!px_emit) begin
				pend_nxt = pend_q + 1'b1;
			end
		end else if (dr_emit) begin
			pend_nxt = pend_q - 1'b1;
		end
	end

	// Queue every pixel item and every drain that produces an output.
	always_comb begin
		push                = acc && (is_pix || dr_emit);
		push_data.is_pixel  = is_pix;
		push_data.emit      = out_adv;
		push_data.blur      = is_pix && blur;
		push_data.frame_end = frame_end;
		push_data.use_mem   = !is_pix && use_mem;
		push_data.addr      = is_pix ? col_q : ocol_q;
		push_data.pix       = pix;
	end

	// Registers and counters; a write to a listed register restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= bb3_pkg::WIDTH_RESET;
			h_q    <= bb3_pkg::HEIGHT_RESET;
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cfg_we && cfg_hit) begin
			if (cfg_index == bb3_pkg::CFG_IDX_WIDTH) begin
				w_q <= bb3_pkg::clamp_dim(cfg_data, bb3_pkg::WIDTH_MIN, bb3_pkg::WIDTH_MAX);
			end else begin
				h_q <= bb3_pkg::clamp_dim(cfg_data, bb3_pkg::HEIGHT_MIN, bb3_pkg::HEIGHT_MAX);
			end
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (acc) begin
			pend_q <= pend_nxt;
			if (is_pix) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
			if (out_adv) begin
				ocol_q <= ocol_nxt;
				orow_q <= orow_nxt;
			end
		end
	end

	`BB3_ASSERT(a_pend_bound, clk, arst_n, pend_q <= bb3_pkg::pend_t'(w_q) + bb3_pkg::pend_t'(1), "pending count above width plus one")
	`BB3_ASSERT(a_col_range, clk, arst_n, bb3_pkg::dim_t'(col_q) < w_q, "input column outside the frame")
	`BB3_ASSERT(a_row_range, clk, arst_n, bb3_pkg::dim_t'(row_q) < h_q, "input row outside the frame")
	`BB3_ASSERT(a_drain_at_start, clk, arst_n, (push && !push_data.is_pixel) |-> (col_q == '0 && row_q == '0 && pend_q != '0), "drain output away from a frame boundary")

endmodule

FILE: sv/bb3_back.sv
// Back end: line buffers, 3x3 window, window sum and divide by nine.
// Pops items from the queue and drives the output register. Uses bb3_pkg.
module bb3_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bb3_pkg::q_entry_t q_data,
	input  logic              q_empty,
	output logic              q_pop,
	input  logic              result_stall,
	output logic              result_valid,
	output bb3_pkg::pix_t     result_pix,
	output logic              frame_end
);

	// Line buffers: newer holds the last row, older the row before it.
	bb3_pkg::pix_t rowbuf_new_q [bb3_pkg::MAX_WIDTH];
	bb3_pkg::pix_t rowbuf_old_q [bb3_pkg::MAX_WIDTH];
	// Window: row 0 newest input row, column 0 newest pixel.
	bb3_pkg::pix_t win_q [3][3];

	logic              adv;
	logic              v_s1;
	bb3_pkg::q_entry_t ent_s1;
	bb3_pkg::pix_t     newer_s1;
	logic              v_s2;
	bb3_pkg::q_entry_t ent_s2;
	bb3_pkg::pix_t     newer_s2;
	bb3_pkg::pix_t     older_s2;
	logic              v_s3;
	logic              emit_s3;
	logic              blur_s3;
	logic              fe_s3;
	bb3_pkg::pix_t     pass_s3;
	logic              v_s4;
	logic              emit_s4;
	logic              blur_s4;
	logic              fe_s4;
	bb3_pkg::pix_t     pass_s4;
	bb3_pkg::rsum_t    rsum_s4 [3][bb3_pkg::NCH];
	logic              v_s5;
	logic              emit_s5;
	logic              blur_s5;
	logic              fe_s5;
	bb3_pkg::pix_t     pass_s5;
	bb3_pkg::sum_t     tsum_s5 [bb3_pkg::NCH];
	logic              res_valid_q;
	bb3_pkg::pix_t     res_pix_q;
	logic              res_fe_q;
	bb3_pkg::prod_t    prod [bb3_pkg::NCH];
	bb3_pkg::pix_t     mean;

	// The whole pipeline moves unless the output holds a stalled item.
	assign adv   = !res_valid_q || !result_stall;
	assign q_pop = adv && !q_empty;

	// Stage 1: newer line buffer, read before write at the same column.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			newer_s1 <= rowbuf_new_q[q_data.addr];
			if (q_data.is_pixel) begin
				rowbuf_new_q[q_data.addr] <= q_data.pix;
			end
		end
	end

	// Stage 2: older line buffer takes what left the newer one.
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			older_s2 <= rowbuf_old_q[ent_s1.addr];
			if (ent_s1.is_pixel) begin
				rowbuf_old_q[ent_s1.addr] <= newer_s1;
			end
		end
	end

	// Stage 3: window shift; the pixel being output is the window center.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (v_s2 && ent_s2.is_pixel) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r][2] <= win_q[r][1];
					win_q[r][1] <= win_q[r][0];
				end
				win_q[0][0] <= ent_s2.pix;
				win_q[1][0] <= newer_s2;
				win_q[2][0] <= older_s2;
			end
			pass_s3 <= ent_s2.use_mem ? newer_s2 : win_q[1][0];
			emit_s3 <= ent_s2.emit;
			blur_s3 <= ent_s2.blur;
			fe_s3   <= ent_s2.frame_end;
		end
	end

	// Stage 4: per row and channel sums of the window.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < bb3_pkg::NCH; c++) begin
					rsum_s4[r][c] <= bb3_pkg::rsum_t'(win_q[r][0][c])
						+ bb3_pkg::rsum_t'(win_q[r][1][c])
						+ bb3_pkg::rsum_t'(win_q[r][2][c]);
				end
			end
			pass_s4 <= pass_s3;
			emit_s4 <= emit_s3;
			blur_s4 <= blur_s3;
			fe_s4   <= fe_s3;
		end
	end

	// Stage 5: full window sum per channel.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < bb3_pkg::NCH; c++) begin
				tsum_s5[c] <= bb3_pkg::sum_t'(rsum_s4[0][c]) + bb3_pkg::sum_t'(rsum_s4[1][c])
					+ bb3_pkg::sum_t'(rsum_s4[2][c]);
			end
			pass_s5 <= pass_s4;
			emit_s5 <= emit_s4;
			blur_s5 <= blur_s4;
			fe_s5   <= fe_s4;
		end
	end

	// Stage 1 and 2 payload registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s1   <= q_data;
			ent_s2   <= ent_s1;
			newer_s2 <= newer_s1;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= q_pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			res_valid_q <= v_s5 && emit_s5;
		end
	end

	// Divide by nine through the reciprocal multiply.
	always_comb begin
		for (int c = 0; c < bb3_pkg::NCH; c++) begin
			prod[c] = bb3_pkg::prod_t'(tsum_s5[c]) * bb3_pkg::prod_t'(bb3_pkg::DIV9_MUL);
			mean[c] = prod[c][bb3_pkg::DIV9_SHIFT +: bb3_pkg::CH_W];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_pix_q <= blur_s5 ? mean : pass_s5;
			res_fe_q  <= fe_s5;
		end
	end

	assign result_valid = res_valid_q;
	assign result_pix   = res_pix_q;
	assign frame_end    = res_fe_q;

endmodule

FILE: sv/box_blur_3x3_rgb.sv
// An accepted item passes through the queue, the back-end stages and the output register
// to produce its output; a pixel itself comes out width+1 pixel items after it went in.
// Throughput: one item per clock while not stalled, set by one access per cycle to each
// line buffer RAM. Reset: asynchronous, clears counters, pipeline and queue and loads
// width 640, height 480; the line buffers are not cleared and need no clearing pass.
module box_blur_3x3_rgb (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bb3_pkg::DIM_W-1:0]    cfg_data,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic                     opcode,
	input  logic [7:0]               blue_in,
	input  logic [7:0]               green_in,
	input  logic [7:0]               red_in,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic [7:0]               blue_out,
	output logic [7:0]               green_out,
	output logic [7:0]               red_out,
	output logic                     frame_end
);

	bb3_pkg::q_entry_t push_data;
	bb3_pkg::q_entry_t q_data;
	bb3_pkg::pix_t     in_pix;
	bb3_pkg::pix_t     out_pix;
	logic              push;
	logic              pop;
	logic              q_empty;
	logic              q_full;

	// Pack the incoming channels.
	always_comb begin
		in_pix[bb3_pkg::CH_BLUE]  = blue_in;
		in_pix[bb3_pkg::CH_GREEN] = green_in;
		in_pix[bb3_pkg::CH_RED]   = red_in;
	end

	assign item_stall = q_full;

	bb3_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.opcode     (opcode),
		.pix        (in_pix),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	bb3_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.data      (q_data),
		.empty     (q_empty),
		.full      (q_full)
	);

	bb3_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_data       (q_data),
		.q_empty      (q_empty),
		.q_pop        (pop),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result_pix   (out_pix),
		.frame_end    (frame_end)
	);

	// Unpack the output channels.
	assign blue_out  = out_pix[bb3_pkg::CH_BLUE];
	assign green_out = out_pix[bb3_pkg::CH_GREEN];
	assign red_out   = out_pix[bb3_pkg::CH_RED];

endmodule
